### rtl/crc_checked_frame_parser_unit_defines.svh
// Assertion macros used by the checker module of the frame parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CRC_CHECKED_FRAME_PARSER_UNIT_DEFINES_SVH
`define CRC_CHECKED_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCFP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ccfp_pkg.sv
package ccfp_pkg;

  // Frame layout and sizing.
  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int HDR_BYTES         = 12;
  localparam int CRC_BYTES         = 2;
  localparam int ADDR_W            = $clog2(MAX_PAYLOAD_BYTES);
  localparam int LEN_W             = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int POS_W             = $clog2(HDR_BYTES + MAX_PAYLOAD_BYTES + CRC_BYTES + 1);
  localparam int LIMIT_W           = 7;
  localparam int TDATA_W           = 80;
  localparam int CFG_IDX_W         = 8;

  // Sync pattern and CRC-16/CCITT-FALSE constants.
  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Header byte positions within the frame.
  localparam int POS_SYNC0   = 0;
  localparam int POS_SYNC1   = 1;
  localparam int POS_VERSION = 2;
  localparam int POS_TYPE    = 3;
  localparam int POS_SEQ_HI  = 4;
  localparam int POS_SEQ_LO  = 5;
  localparam int POS_TS_HI   = 6;
  localparam int POS_TS_LO   = 9;
  localparam int POS_LEN_LO  = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = CFG_IDX_W'(1);

  // Result item as packed on out_tdata, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]       pad;
    logic [7:0]       payload_byte;
    logic [ADDR_W-1:0] payload_index;
    logic [LEN_W-1:0] payload_count;
    logic [31:0]      stamp_ms;
    logic [15:0]      sequence_res;
    logic [7:0]       msg_type;
  } out_item_t;

  // One byte through the MSB-first CRC-16 shift register.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/crc_checked_frame_parser_unit.sv
// Frame parser for a received byte stream: it hunts for the sync pair 0xA5 0x5A, collects a
// 12-byte big-endian header, stores the payload in a 64-entry byte memory while folding every
// byte ahead of the CRC bytes into a CRC-16/CCITT-FALSE, and checks that CRC against the two
// CRC bytes that close the frame. Frames with a wrong version, a length above payload_limit or
// a bad CRC are dropped without any result. While a frame is received the block takes one byte
// per cycle. After the last CRC byte of a good frame it reads the payload memory back through
// its single read port, one result at a time (read, then load of the output register), and a
// load waits while the previous result is stalled on out_tready; an empty payload gives one
// result. in_tready is low during that burst and high again once the last result sits in the
// output register. The memory needs no clearing after reset, and configuration writes are taken in every cycle.
module crc_checked_frame_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] msg_type, [23:8] sequence_res, [55:24] stamp_ms, [62:56] payload_count,
  // [68:63] payload_index, [76:69] payload_byte, [79:77] zero
  output logic [ccfp_pkg::TDATA_W-1:0]        out_tdata,
  output logic [0:0]                          out_tuser,  // [0] payload_valid
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ccfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import ccfp_pkg::*;

  typedef enum logic [1:0] {S_RX, S_RD, S_LD} state_t;

  state_t              state_r;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    ftl_r;
  logic [15:0]         crc_r;
  logic [15:0]         rcrc_r;
  logic [7:0]          ver_r;
  logic [7:0]          type_r;
  logic [15:0]         seq_r;
  logic [31:0]         ts_r;
  logic [15:0]         len_r;
  logic [7:0]          ver_exp_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [ADDR_W-1:0]   k_r;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic                out_user_r;
  logic                out_last_r;

  logic [7:0]          mem [MAX_PAYLOAD_BYTES];
  logic [7:0]          rd_data_r;

  logic [7:0]          b;
  logic                in_xfer;
  logic [15:0]         crc_next;
  logic [15:0]         crc_sync;
  logic [15:0]         len_new;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    payload_end;
  logic                in_payload;
  logic                len_bad;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   waddr;
  logic                load_out;
  logic [LEN_W-1:0]    n_len;
  logic                emit_last;

  // Byte decode helpers.
  always_comb begin
    b           = in_tdata;
    in_xfer     = in_tvalid && in_tready;
    crc_next    = crc_feed(crc_r, b);
    crc_sync    = crc_feed(CRC_INIT, b);
    len_new     = {len_r[7:0], b};
    pos_inc     = pos_r + POS_W'(1);
    payload_end = POS_W'(HDR_BYTES) + POS_W'(len_r[LEN_W-1:0]);
    in_payload  = (pos_r >= POS_W'(HDR_BYTES)) && (pos_r < payload_end);
    len_bad     = (ver_r != ver_exp_r) || (len_new > 16'(limit_r)) ||
                  (len_new > 16'(MAX_PAYLOAD_BYTES));
    waddr       = ADDR_W'(pos_r - POS_W'(HDR_BYTES));
    mem_we      = in_xfer && in_payload && (ftl_r != '0) && (pos_r < ftl_r);
    mem_re      = (state_r == S_RD);
    load_out    = (state_r == S_LD) && (!out_valid_r || out_tready);
    n_len       = len_r[LEN_W-1:0];
    emit_last   = (n_len == '0) || ((LEN_W'(k_r) + LEN_W'(1)) == n_len);
  end

  // Payload memory: written while the frame arrives, read back during emission.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= b;
    end
    if (mem_re) begin
      rd_data_r <= mem[k_r];
    end
  end

  // Receive, emission sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      pos_r       <= '0;
      ftl_r       <= '0;
      crc_r       <= CRC_INIT;
      rcrc_r      <= '0;
      ver_r       <= '0;
      type_r      <= '0;
      seq_r       <= '0;
      ts_r        <= '0;
      len_r       <= '0;
      ver_exp_r   <= 8'd1;
      limit_r     <= LIMIT_W'(MAX_PAYLOAD_BYTES);
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes; unknown indexes are ignored.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_VERSION: ver_exp_r <= cfg_data;
          CFG_LIMIT:   limit_r   <= cfg_data[LIMIT_W-1:0];
          default:     ;
        endcase
      end

      // The output slot frees up on a transfer unless refilled below.
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_RX: begin
          if (in_xfer) begin
            if (pos_r == POS_W'(POS_SYNC0)) begin
              // Hunting for the first sync byte.
              if (b == SYNC_FIRST) begin
                crc_r <= crc_sync;
                pos_r <= POS_W'(POS_SYNC1);
              end
            end else if (pos_r == POS_W'(POS_SYNC1)) begin
              // A repeated first sync byte restarts the frame at that byte.
              if (b == SYNC_SECOND) begin
                crc_r <= crc_next;
                pos_r <= POS_W'(POS_VERSION);
              end else if (b == SYNC_FIRST) begin
                crc_r <= crc_sync;
              end else begin
                pos_r  <= '0;
                ftl_r  <= '0;
                crc_r  <= CRC_INIT;
                rcrc_r <= '0;
              end
            end else if (pos_r < POS_W'(HDR_BYTES)) begin
              crc_r <= crc_next;
              pos_r <= pos_inc;
              case (pos_r) inside
                POS_VERSION:            ver_r  <= b;
                POS_TYPE:               type_r <= b;
                [POS_SEQ_HI:POS_SEQ_LO]: seq_r <= {seq_r[7:0], b};
                [POS_TS_HI:POS_TS_LO]:  ts_r   <= {ts_r[23:0], b};
                default:                len_r  <= len_new;
              endcase
              // Version and length are checked on the last header byte.
              if (pos_r == POS_W'(POS_LEN_LO)) begin
                if (len_bad) begin
                  pos_r  <= '0;
                  ftl_r  <= '0;
                  crc_r  <= CRC_INIT;
                  rcrc_r <= '0;
                end else begin
                  ftl_r <= POS_W'(HDR_BYTES + CRC_BYTES) + POS_W'(len_new[LEN_W-1:0]);
                end
              end
            end else if ((ftl_r == '0) || (pos_r >= ftl_r)) begin
              pos_r  <= '0;
              ftl_r  <= '0;
              crc_r  <= CRC_INIT;
              rcrc_r <= '0;
            end else begin
              // Payload bytes feed the CRC; the trailing two bytes are the received CRC.
              if (in_payload) begin
                crc_r <= crc_next;
              end else begin
                rcrc_r <= {rcrc_r[7:0], b};
              end
              pos_r <= pos_inc;
              if (pos_inc == ftl_r) begin
                pos_r  <= '0;
                ftl_r  <= '0;
                crc_r  <= CRC_INIT;
                rcrc_r <= '0;
                if ({rcrc_r[7:0], b} == crc_r) begin
                  state_r <= S_RD;
                  k_r     <= '0;
                end
              end
            end
          end
        end

        S_RD: begin
          state_r <= S_LD;
        end

        S_LD: begin
          if (load_out) begin
            out_valid_r                <= 1'b1;
            out_item_r.pad             <= '0;
            out_item_r.msg_type        <= type_r;
            out_item_r.sequence_res    <= seq_r;
            out_item_r.stamp_ms        <= ts_r;
            out_item_r.payload_count   <= n_len;
            out_last_r                 <= emit_last;
            // An empty payload gives one result without data.
            if (n_len == '0) begin
              out_item_r.payload_index <= '0;
              out_item_r.payload_byte  <= '0;
              out_user_r               <= 1'b0;
            end else begin
              out_item_r.payload_index <= k_r;
              out_item_r.payload_byte  <= rd_data_r;
              out_user_r               <= 1'b1;
            end
            if (emit_last) begin
              state_r <= S_RX;
            end else begin
              k_r     <= k_r + ADDR_W'(1);
              state_r <= S_RD;
            end
          end
        end

        default: state_r <= S_RX;
      endcase
    end
  end

  assign in_tready    = (state_r == S_RX);
  assign cfg_ready    = 1'b1;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_item_r;
  assign out_tuser[0] = out_user_r;
  assign out_tlast    = out_last_r;

endmodule

### rtl/ccfp_checker.sv
`include "crc_checked_frame_parser_unit_defines.svh"

module ccfp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [ccfp_pkg::TDATA_W-1:0] out_tdata,
  input logic [0:0]                   out_tuser,
  input logic                         out_tlast
);
  import ccfp_pkg::*;

  out_item_t          item;
  logic [TDATA_W+1:0] beat;
  logic               stall;
  logic               empty_beat;
  logic               empty_ok;
  logic               data_beat;
  logic [LEN_W-1:0]   idx_ext;
  logic               idx_final;

  assign item       = out_tdata;
  assign beat       = {out_tlast, out_tuser, out_tdata};
  assign stall      = out_tvalid && !out_tready;
  assign empty_beat = out_tvalid && !out_tuser[0];
  assign empty_ok   = out_tlast && (item.payload_count == '0) &&
                      (item.payload_index == '0) && (item.payload_byte == '0);
  assign data_beat  = out_tvalid && out_tuser[0];
  assign idx_ext    = LEN_W'(item.payload_index);
  assign idx_final  = ((idx_ext + LEN_W'(1)) == item.payload_count);

  // A stalled result keeps its contents.
  `CCFP_ASSERT_NEXT(a_out_hold, stall, out_tvalid && $stable(beat), "stalled result changed")

  // A result without data stands alone for an empty payload.
  `CCFP_ASSERT_IMPLY(a_empty_form, empty_beat, empty_ok, "empty-payload result malformed")

  // A data result points inside the payload.
  `CCFP_ASSERT_IMPLY(a_index_range, data_beat, idx_ext < item.payload_count, "index beyond length")

  // The last data result carries the final payload index.
  `CCFP_ASSERT_IMPLY(a_last_index, data_beat, out_tlast == idx_final, "last flag does not match")

endmodule

bind crc_checked_frame_parser_unit ccfp_checker u_ccfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### test/crc_checked_frame_parser_unit_tb.sv
module crc_checked_frame_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfp_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;

  // One expected result transfer: the packed tdata fields plus tuser and tlast.
  typedef struct packed {
    out_item_t item;
    logic      payload_valid;
    logic      last;
  } parsed_beat_t;

  // Receiver pacing styles.
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pace_t;

  // Kinds of byte sequences the random stimulus produces.
  typedef enum int {
    FR_GOOD, FR_BAD_CRC, FR_BAD_VERSION, FR_OVERSIZE, FR_BROKEN_SYNC, FR_TRUNCATED, FR_NOISE
  } frame_kind_t;

  // Byte-level model of the parser plus the queue of result transfers it predicts.
  class frame_predictor;
    logic [7:0]  expected_version;
    logic [6:0]  payload_limit;
    logic [6:0]  position;
    logic [6:0]  total_len;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_seq;
    logic [31:0] hdr_ts;
    logic [15:0] hdr_len;
    logic [7:0]  payload_mem [MAX_PAYLOAD_BYTES];
    parsed_beat_t pending_beats[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned beats_predicted;
    int unsigned frames_accepted;

    function new();
      expected_version = 8'd1;
      payload_limit    = 7'd64;
      hdr_version      = '0;
      hdr_type         = '0;
      hdr_seq          = '0;
      hdr_ts           = '0;
      hdr_len          = '0;
      mismatches       = 0;
      beats_checked    = 0;
      beats_predicted  = 0;
      frames_accepted  = 0;
      restart_hunt();
    endfunction

    // MSB-first CRC-16 update, polynomial 0x1021, one byte at a time.
    static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int i;
      c = crc ^ {b, 8'h00};
      for (i = 0; i < 8; i++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void restart_hunt();
      position  = '0;
      total_len = '0;
      crc_run   = CRC_INIT;
      crc_rx    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_VERSION) begin
        expected_version = value;
      end else if (idx == CFG_LIMIT) begin
        payload_limit = value[LIMIT_W-1:0];
      end
    endfunction

    // Advance the parser by one accepted byte and queue any results it releases.
    function void take_byte(logic [7:0] b);
      parsed_beat_t beat;
      int unsigned n;
      int unsigned k;
      if (position == POS_SYNC0) begin
        if (b == SYNC_FIRST) begin
          crc_run  = crc16_step(CRC_INIT, b);
          position = 7'd1;
        end
        return;
      end
      if (position == POS_SYNC1) begin
        if (b == SYNC_SECOND) begin
          crc_run  = crc16_step(crc_run, b);
          position = 7'd2;
        end else if (b == SYNC_FIRST) begin
          // A second 0xA5 becomes the first byte of a new frame.
          crc_run = crc16_step(CRC_INIT, b);
        end else begin
          restart_hunt();
        end
        return;
      end
      if (position < HDR_BYTES) begin
        crc_run = crc16_step(crc_run, b);
        case (position)
          POS_VERSION: hdr_version = b;
          POS_TYPE: hdr_type = b;
          POS_SEQ_HI, POS_SEQ_LO: hdr_seq = {hdr_seq[7:0], b};
          POS_TS_HI, POS_TS_HI + 1, POS_TS_HI + 2, POS_TS_LO: hdr_ts = {hdr_ts[23:0], b};
          default: hdr_len = {hdr_len[7:0], b};
        endcase
        // Version and length are judged only once the whole header is in.
        if (position == POS_LEN_LO) begin
          if (hdr_version != expected_version || hdr_len > payload_limit ||
              hdr_len > MAX_PAYLOAD_BYTES) begin
            restart_hunt();
            return;
          end
          total_len = 7'(HDR_BYTES + hdr_len + CRC_BYTES);
        end
        position++;
        return;
      end
      if (total_len == 0 || position >= total_len) begin
        restart_hunt();
        return;
      end
      if (position < HDR_BYTES + hdr_len) begin
        payload_mem[position - HDR_BYTES] = b;
        crc_run = crc16_step(crc_run, b);
      end else begin
        crc_rx = {crc_rx[7:0], b};
      end
      position++;
      if (position < total_len) begin
        return;
      end
      if (crc_rx != crc_run) begin
        restart_hunt();
        return;
      end
      // Good frame: one result per payload byte, or a single one for an empty payload.
      frames_accepted++;
      n = 32'(hdr_len);
      k = 0;
      do begin
        beat = '0;
        beat.item.msg_type       = hdr_type;
        beat.item.sequence_res   = hdr_seq;
        beat.item.stamp_ms       = hdr_ts;
        beat.item.payload_count  = LEN_W'(n);
        if (n == 0) begin
          beat.last = 1'b1;
        end else begin
          beat.item.payload_index = ADDR_W'(k);
          beat.item.payload_byte  = payload_mem[k];
          beat.payload_valid      = 1'b1;
          beat.last               = (k + 1 == n);
        end
        pending_beats.push_back(beat);
        beats_predicted++;
        k++;
      end while (k < n);
      restart_hunt();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("transfer %0d field %s: got 0x%0h, expected 0x%0h",
                         beats_checked, name, got, want));
      end
    endtask

    // Compare one result transfer against the oldest prediction.
    task check_beat(logic [TDATA_W-1:0] tdata, logic tuser_valid, logic tlast);
      out_item_t    got;
      parsed_beat_t want;
      got = tdata;
      if (pending_beats.size() == 0) begin
        report($sformatf("result transfer with nothing pending, tdata 0x%0h", tdata));
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      compare_field("msg_type", got.msg_type, want.item.msg_type);
      compare_field("sequence_res", got.sequence_res, want.item.sequence_res);
      compare_field("stamp_ms", got.stamp_ms, want.item.stamp_ms);
      compare_field("payload_count", got.payload_count, want.item.payload_count);
      compare_field("payload_index", got.payload_index, want.item.payload_index);
      compare_field("payload_byte", got.payload_byte, want.item.payload_byte);
      compare_field("pad", got.pad, want.item.pad);
      compare_field("payload_valid", tuser_valid, want.payload_valid);
      compare_field("last", tlast, want.last);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [TDATA_W-1:0]   out_tdata;
  logic [0:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  frame_predictor pred = new();

  logic [7:0]  tx_bytes[$];
  logic [7:0]  cur_version = 8'd1;
  logic [6:0]  cur_limit   = 7'd64;
  bit          hold_armed  = 1'b0;
  int unsigned holds_done  = 0;
  int unsigned burst_left  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned settings_used = 0;

  crc_checked_frame_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Transfer monitors feed the predictor and the checker.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pred.take_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pred.check_beat(out_tdata, out_tuser[0], out_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      pred.write_reg(cfg_index, cfg_data);
    end
  end

  // Receiver: switches between random pacing styles; one long hold when armed.
  initial begin : receiver
    rx_pace_t pace;
    int       pace_left;
    int       hold_left;
    int       cyc;
    out_tready <= 1'b0;
    pace      = RX_ALWAYS;
    pace_left = 0;
    hold_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (pace_left == 0) begin
        pace      = rx_pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(20, 80);
      end
      pace_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_armed && out_tvalid) begin
        hold_armed = 1'b0;
        hold_left  = LONG_HOLD;
        holds_done++;
        out_tready <= 1'b0;
      end else begin
        case (pace)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_COIN: out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  // Offer one byte, opening a random gap whenever the current burst runs out.
  task automatic send_byte(logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_all();
    while (tx_bytes.size() != 0) begin
      send_byte(tx_bytes.pop_front());
    end
  endtask

  // Append a complete frame to the send queue; oversized lengths carry a short body.
  function automatic void build_frame(logic [7:0] version, logic [7:0] kind_byte,
                                      logic [15:0] seq, logic [31:0] stamp,
                                      logic [15:0] len, int fill, bit corrupt_crc);
    logic [7:0]  f[$];
    logic [15:0] crc;
    int          n_body;
    f = '{SYNC_FIRST, SYNC_SECOND, version, kind_byte, seq[15:8], seq[7:0],
          stamp[31:24], stamp[23:16], stamp[15:8], stamp[7:0], len[15:8], len[7:0]};
    n_body = (len > MAX_PAYLOAD_BYTES) ? 8 : int'(len);
    repeat (n_body) f.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    crc = CRC_INIT;
    foreach (f[i]) crc = frame_predictor::crc16_step(crc, f[i]);
    if (corrupt_crc) begin
      crc ^= 16'($urandom_range(1, 65535));
    end
    f.push_back(crc[15:8]);
    f.push_back(crc[7:0]);
    foreach (f[i]) tx_bytes.push_back(f[i]);
  endfunction

  task automatic cfg_transfer(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both registers, then a stray index that the block must ignore.
  task automatic program_regs(logic [7:0] version, logic [7:0] limit_raw,
                              logic [CFG_IDX_W-1:0] stray_index);
    cfg_transfer(CFG_VERSION, version);
    cfg_transfer(CFG_LIMIT, limit_raw);
    cfg_transfer(stray_index, 8'($urandom));
    cfg_valid   <= 1'b0;
    cur_version  = version;
    cur_limit    = limit_raw[LIMIT_W-1:0];
    settings_used++;
  endtask

  // Stop offering, wait for every predicted result, then let the block go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pred.pending_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, mixed with broken ones and noise.
  task automatic random_traffic(int unsigned byte_goal);
    int unsigned sent;
    int unsigned chunk;
    int          roll;
    int          eff;
    logic [15:0] len;
    logic [7:0]  junk;
    frame_kind_t kind;
    sent = 0;
    while (sent < byte_goal) begin
      eff  = (cur_limit > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(cur_limit);
      roll = $urandom_range(0, 99);
      kind = (roll < 62) ? FR_GOOD : (roll < 70) ? FR_BAD_CRC : (roll < 76) ? FR_BAD_VERSION :
             (roll < 82) ? FR_OVERSIZE : (roll < 88) ? FR_BROKEN_SYNC :
             (roll < 94) ? FR_TRUNCATED : FR_NOISE;
      len  = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, eff)
                                             : $urandom_range(0, (eff < 8) ? eff : 8));
      if (kind != FR_NOISE && $urandom_range(0, 4) == 0) begin
        tx_bytes.push_back(SYNC_FIRST);
      end
      case (kind)
        FR_GOOD, FR_TRUNCATED, FR_BAD_CRC: begin
          build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, len, -1,
                      kind == FR_BAD_CRC);
        end
        FR_BAD_VERSION: begin
          build_frame(cur_version ^ 8'($urandom_range(1, 255)), 8'($urandom), 16'($urandom),
                      $urandom, len, -1, 1'b0);
        end
        FR_OVERSIZE: begin
          len = ($urandom_range(0, 3) == 0) ? {8'($urandom_range(1, 255)), 8'($urandom)}
                                            : 16'(eff + $urandom_range(1, 10));
          build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, len, -1, 1'b0);
        end
        FR_BROKEN_SYNC: begin
          do junk = 8'($urandom); while (junk == SYNC_FIRST || junk == SYNC_SECOND);
          tx_bytes.push_back(SYNC_FIRST);
          tx_bytes.push_back(junk);
        end
        default: begin
          repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
        end
      endcase
      if (kind == FR_TRUNCATED) begin
        repeat ($urandom_range(1, tx_bytes.size() - 3)) void'(tx_bytes.pop_back());
      end
      chunk = tx_bytes.size();
      send_all();
      if (kind != FR_NOISE) begin
        sent += chunk;
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Run aborted: the block did not drain within the time limit.");
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: stray bytes while hunting, then a repeated sync start
    // in front of an empty frame with all-ones type, sequence and timestamp.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(SYNC_SECOND);
    tx_bytes.push_back(SYNC_FIRST);
    build_frame(cur_version, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, -1, 1'b0);
    // A bad second sync byte, then a frame with zero type, sequence and timestamp and one zero payload byte.
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(8'h00);
    build_frame(cur_version, 8'h00, 16'h0000, 32'h0000_0000, 16'd1, 0, 1'b0);
    // Frames that must vanish: wrong version, length over the limit, length with a
    // nonzero high byte, and a corrupted CRC.
    build_frame(cur_version + 8'd1, 8'($urandom), 16'($urandom), $urandom, 16'd3, -1, 1'b0);
    build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, 16'd65, -1, 1'b0);
    build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, 16'h0102, -1, 1'b0);
    build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, 16'd4, -1, 1'b1);
    send_all();

    // Two full-size payloads while the receiver holds off; the sender keeps offering.
    // The last header carries sync patterns inside its sequence and timestamp.
    hold_armed = 1'b1;
    build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, 16'd64, -1, 1'b0);
    build_frame(cur_version, 8'($urandom), 16'($urandom), $urandom, 16'd64, 255, 1'b0);
    build_frame(cur_version, SYNC_SECOND, 16'hA55A, 32'h5AA5_A55A, 16'd5, -1, 1'b0);
    send_all();
    settle();

    // Random phases over several register settings, extremes included.
    program_regs(8'h00, 8'h00, 8'hFF);
    random_traffic(15);
    settle();
    program_regs(8'hFF, 8'h80 | 8'd40, 8'($urandom_range(2, 254)));
    random_traffic(15);
    settle();
    program_regs(8'($urandom_range(2, 254)), 8'd100, 8'h02);
    random_traffic(20);
    settle();
    program_regs(8'($urandom), 8'd64, 8'h80);
    random_traffic(20);
    while (pred.beats_predicted < 60) begin
      random_traffic(20);
    end
    settle();

    $display("Covered %0d received bytes under %0d register settings and %0d long output hold(s).",
             bytes_sent, settings_used + 1, holds_done);
    $display("%0d frames passed the CRC check; %0d result transfers compared, %0d mismatches.",
             pred.frames_accepted, pred.beats_checked, pred.mismatches);
    if (pred.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ccfp_pkg.sv
rtl/crc_checked_frame_parser_unit.sv
rtl/ccfp_checker.sv
test/crc_checked_frame_parser_unit_tb.sv
